FILE: rtl/vap_pkg.sv
// ----------------------------------------------------------------------------
// Vertex attribute packer package
// Shared payload types, constants and small arithmetic helpers.
// ----------------------------------------------------------------------------
package vap_pkg;

   localparam int MAX_NORMAL_SCALE = 127;
   localparam int CELL_DEPTH       = 5;

   localparam logic [23:0] POS_OFFSET  = 24'h800000;
   localparam logic [23:0] POS_MAX     = 24'hFFFFFF;
   localparam logic [9:0]  POS_SCALE   = 10'd1000;
   localparam logic [31:0] ATTR_WHITE  = 32'h0000FFFF;
   localparam logic [15:0] UNORM_RECIP = 16'd32897;

   localparam logic [5:0] LEVELS_31 = 6'd31;
   localparam logic [5:0] LEVELS_63 = 6'd63;
   localparam logic [5:0] LEVELS_15 = 6'd15;
   localparam logic [5:0] LEVELS_7  = 6'd7;
   localparam logic [5:0] LEVELS_3  = 6'd3;
   localparam logic [5:0] LEVELS_1  = 6'd1;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [63:0]        channel_reds;
      logic [7:0]         color_green;
      logic [7:0]         color_blue;
   } req_type;

   typedef struct packed {
      logic [31:0] word_x;
      logic [31:0] word_y;
      logic [31:0] word_z;
      logic [31:0] word_attr;
   } rsp_type;

   // Per-vertex data that rides along the normal search.
   typedef struct packed {
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [23:0] pos_z;
      logic [31:0] attr;
      logic [2:0]  nneg;
      logic [15:0] nmag_x;
      logic [15:0] nmag_y;
      logic [15:0] nmag_z;
   } vtx_type;

   // Best candidate found so far; d2 is the squared dot product.
   typedef struct packed {
      logic        have;
      logic [6:0]  t_x;
      logic [6:0]  t_y;
      logic [6:0]  t_z;
      logic [47:0] d2;
      logic [15:0] tt;
   } best_type;

   // Rounds c * k / 255 to nearest; the reciprocal is exact for this range.
   function automatic logic [5:0] unorm(input logic [7:0] c, input logic [5:0] k);
      logic [14:0] n;
      logic [31:0] p;
      n = 15'({1'b0, ({6'd0, c} * {8'd0, k})} << 1) + 15'd255;
      p = {17'd0, n} * {16'd0, UNORM_RECIP};
      return p[29:24];
   endfunction

   // Magnitude of a Q1.15 component.
   function automatic logic [15:0] nmag(input logic signed [15:0] v);
      return v[15] ? 16'(-v) : 16'(v);
   endfunction

endpackage

FILE: rtl/vap_front.sv
// ----------------------------------------------------------------------------
// Vertex attribute packer front end
// Position scaling and clamping, attribute quantizing, normal magnitudes.
// ----------------------------------------------------------------------------
module vap_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  vap_pkg::req_type  in_data,
   input  logic              channels_on,
   output logic              out_valid,
   output vap_pkg::vtx_type  out_vtx
);

   logic             v1_ff, v1_in;
   logic [41:0]      prod_ff [3];
   logic [41:0]      prod_in [3];
   logic [2:0]       pneg_ff, pneg_in;
   vap_pkg::vtx_type vtx1_ff, vtx1_in;
   logic             v2_ff;
   vap_pkg::vtx_type vtx2_ff, vtx2_in;
   logic [31:0]      praw [3];
   logic [31:0]      pmag [3];
   logic [42:0]      rsum [3];
   logic [24:0]      q    [3];
   logic [23:0]      pout [3];
   logic [63:0]      reds;
   logic [5:0]       quant [10];

   always_comb begin
      praw[0] = in_data.pos_x;
      praw[1] = in_data.pos_y;
      praw[2] = in_data.pos_z;
      reds    = in_data.channel_reds;
      v1_in   = in_valid;
      for (int i = 0; i < 3; i++) begin
         pneg_in[i] = praw[i][31];
         pmag[i]    = praw[i][31] ? 32'(-praw[i]) : praw[i];
         prod_in[i] = {10'd0, pmag[i]} * {32'd0, vap_pkg::POS_SCALE};
      end
      vtx1_in        = '0;
      vtx1_in.nneg   = {in_data.norm_z[15], in_data.norm_y[15], in_data.norm_x[15]};
      vtx1_in.nmag_x = vap_pkg::nmag(in_data.norm_x);
      vtx1_in.nmag_y = vap_pkg::nmag(in_data.norm_y);
      vtx1_in.nmag_z = vap_pkg::nmag(in_data.norm_z);
      quant[0] = vap_pkg::unorm(reds[7:0], vap_pkg::LEVELS_31);
      quant[1] = vap_pkg::unorm(in_data.color_green, vap_pkg::LEVELS_63);
      quant[2] = vap_pkg::unorm(in_data.color_blue, vap_pkg::LEVELS_31);
      quant[3] = vap_pkg::unorm(reds[15:8], vap_pkg::LEVELS_1);
      quant[4] = vap_pkg::unorm(reds[23:16], vap_pkg::LEVELS_15);
      quant[5] = vap_pkg::unorm(reds[31:24], vap_pkg::LEVELS_7);
      quant[6] = vap_pkg::unorm(reds[39:32], vap_pkg::LEVELS_7);
      quant[7] = vap_pkg::unorm(reds[47:40], vap_pkg::LEVELS_1);
      quant[8] = vap_pkg::unorm(reds[55:48], vap_pkg::LEVELS_3);
      quant[9] = vap_pkg::unorm(reds[63:56], vap_pkg::LEVELS_3);
      if (channels_on) begin
         vtx1_in.attr = {quant[9][1:0], quant[8][1:0], quant[7][0], quant[6][2:0],
                         quant[5][2:0], quant[4][3:0], quant[3][0], quant[2][4:0],
                         quant[1], quant[0][4:0]};
      end else begin
         vtx1_in.attr = vap_pkg::ATTR_WHITE;
      end
   end

   // Second stage: round, offset and saturate the positions.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsum[i] = {1'b0, prod_ff[i]} + 43'd32768;
         q[i]    = rsum[i][40:16];
         if (pneg_ff[i]) begin
            pout[i] = (q[i] > {1'b0, vap_pkg::POS_OFFSET}) ? 24'd0
                    : 24'({1'b0, vap_pkg::POS_OFFSET} - q[i]);
         end else begin
            pout[i] = (q[i] > {1'b0, vap_pkg::POS_MAX - vap_pkg::POS_OFFSET})
                    ? vap_pkg::POS_MAX
                    : 24'({1'b0, vap_pkg::POS_OFFSET} + q[i]);
         end
      end
      vtx2_in       = vtx1_ff;
      vtx2_in.pos_x = pout[0];
      vtx2_in.pos_y = pout[1];
      vtx2_in.pos_z = pout[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
      prod_ff <= prod_in;
      pneg_ff <= pneg_in;
      vtx1_ff <= vtx1_in;
      vtx2_ff <= vtx2_in;
   end

   assign out_valid = v2_ff;
   assign out_vtx   = vtx2_ff;

endmodule

FILE: rtl/vap_scale_cell.sv
// ----------------------------------------------------------------------------
// Vertex attribute packer scale cell
// Tests one integer scale of the normal against the best candidate so far.
// ----------------------------------------------------------------------------
module vap_scale_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic [6:0]         scale,
   input  logic               in_valid,
   input  vap_pkg::vtx_type   in_vtx,
   input  vap_pkg::best_type  in_best,
   output logic               out_valid,
   output vap_pkg::vtx_type   out_vtx,
   output vap_pkg::best_type  out_best
);

   logic [4:0]        v_ff;
   vap_pkg::vtx_type  vtx_ff  [5];
   vap_pkg::best_type best_ff [5];
   vap_pkg::best_type best_in;
   logic [20:0]       t1_ff, t2_ff, t3_ff, t4_ff, t1_in;
   logic [23:0]       d2s_ff, d2s_in;
   logic [15:0]       tt2_ff, tt3_ff, tt4_ff, tt2_in;
   logic [47:0]       dsq3_ff, dsq4_ff, dsq3_in;
   logic [63:0]       p1_ff, p2_ff, p1_in, p2_in;
   logic              nz4_ff, nz4_in;
   logic [15:0]       nm   [3];
   logic [23:0]       tsum [3];
   logic [6:0]        tv   [3];
   logic [24:0]       dsum;
   logic              take;

   // Stage 1: rounded candidate components.
   always_comb begin
      nm[0] = in_vtx.nmag_x;
      nm[1] = in_vtx.nmag_y;
      nm[2] = in_vtx.nmag_z;
      for (int i = 0; i < 3; i++) begin
         tsum[i] = 24'({7'd0, nm[i]} * {16'd0, scale}) + 24'd16384;
      end
      t1_in = {tsum[2][21:15], tsum[1][21:15], tsum[0][21:15]};
   end

   // Stage 2: dot product and squared length of the candidate.
   always_comb begin
      tv[0] = t1_ff[6:0];
      tv[1] = t1_ff[13:7];
      tv[2] = t1_ff[20:14];
      dsum  = 25'({9'd0, vtx_ff[0].nmag_x} * {18'd0, tv[0]})
            + 25'({9'd0, vtx_ff[0].nmag_y} * {18'd0, tv[1]})
            + 25'({9'd0, vtx_ff[0].nmag_z} * {18'd0, tv[2]});
      d2s_in = dsum[23:0];
      tt2_in = 16'({9'd0, tv[0]} * {9'd0, tv[0]})
             + 16'({9'd0, tv[1]} * {9'd0, tv[1]})
             + 16'({9'd0, tv[2]} * {9'd0, tv[2]});
   end

   // Stages 3 to 5: square, cross products, compare.
   always_comb begin
      dsq3_in = {24'd0, d2s_ff} * {24'd0, d2s_ff};
      p1_in   = {16'd0, dsq3_ff} * {48'd0, best_ff[2].tt};
      p2_in   = {16'd0, best_ff[2].d2} * {48'd0, tt3_ff};
      nz4_in  = (t3_ff != '0);
      take    = nz4_ff && (!best_ff[3].have || (p1_ff > p2_ff));
      best_in = best_ff[3];
      if (take) begin
         best_in.have = 1'b1;
         best_in.t_x  = t4_ff[6:0];
         best_in.t_y  = t4_ff[13:7];
         best_in.t_z  = t4_ff[20:14];
         best_in.d2   = dsq4_ff;
         best_in.tt   = tt4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], in_valid};
      end
      vtx_ff[0]  <= in_vtx;
      best_ff[0] <= in_best;
      for (int k = 1; k < 5; k++) begin
         vtx_ff[k] <= vtx_ff[k-1];
      end
      for (int k = 1; k < 4; k++) begin
         best_ff[k] <= best_ff[k-1];
      end
      best_ff[4] <= best_in;
      t1_ff   <= t1_in;
      t2_ff   <= t1_ff;
      t3_ff   <= t2_ff;
      t4_ff   <= t3_ff;
      d2s_ff  <= d2s_in;
      tt2_ff  <= tt2_in;
      tt3_ff  <= tt2_ff;
      tt4_ff  <= tt3_ff;
      dsq3_ff <= dsq3_in;
      dsq4_ff <= dsq3_ff;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      nz4_ff  <= nz4_in;
   end

   assign out_valid = v_ff[4];
   assign out_vtx   = vtx_ff[4];
   assign out_best  = best_ff[4];

`ifndef ASSERT_OFF
   a_have_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_best.have |-> out_best.d2 != '0 && out_best.tt != '0)
      else $error("chosen candidate has zero length");

   a_have_keeps: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] && best_ff[3].have |=> best_ff[4].have)
      else $error("best candidate was dropped");

   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##5 out_valid)
      else $error("request lost inside scale cell");
`endif

endmodule

FILE: rtl/vertex_attribute_packer_unit.sv
// ----------------------------------------------------------------------------
// Vertex attribute packer
// Packs one vertex into four 32-bit words: positions with normal codes, and
// an attribute word.
// ----------------------------------------------------------------------------
// The block takes one request in every clock cycle and never raises busy.
// Each request produces exactly one response, with rsp_valid high for one
// cycle, once the request has passed the front end (position scaling and
// clamping, attribute quantizing) and a chain of 127 scale cells, which
// search the normal scales one after another. The receiver cannot stall;
// responses come out in request order at the rate the requests went in. The
// material channel register is written through csr_we and csr_wdata and
// should only change while no request is in flight.
module vertex_attribute_packer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vap_pkg::req_type req_data,
   output logic             rsp_valid,
   output vap_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   logic              channels_ff;
   logic              chan_valid [vap_pkg::MAX_NORMAL_SCALE + 1];
   vap_pkg::vtx_type  chan_vtx   [vap_pkg::MAX_NORMAL_SCALE + 1];
   vap_pkg::best_type chan_best  [vap_pkg::MAX_NORMAL_SCALE + 1];
   vap_pkg::vtx_type  last_vtx;
   vap_pkg::best_type last_best;

   // The pipeline never backs up, so requests are always taken.
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff <= 1'b0;
      end else if (csr_we) begin
         channels_ff <= csr_wdata;
      end
   end

   vap_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start),
      .in_data     (req_data),
      .channels_on (channels_ff),
      .out_valid   (chan_valid[0]),
      .out_vtx     (chan_vtx[0])
   );

   // No candidate has been found when the search begins.
   assign chan_best[0] = '0;

   for (genvar i = 0; i < vap_pkg::MAX_NORMAL_SCALE; i++) begin : g_scale
      vap_scale_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .scale     (7'(i + 1)),
         .in_valid  (chan_valid[i]),
         .in_vtx    (chan_vtx[i]),
         .in_best   (chan_best[i]),
         .out_valid (chan_valid[i+1]),
         .out_vtx   (chan_vtx[i+1]),
         .out_best  (chan_best[i+1])
      );
   end

   // The last cell's registers drive the response directly.
   assign last_vtx  = chan_vtx[vap_pkg::MAX_NORMAL_SCALE];
   assign last_best = chan_best[vap_pkg::MAX_NORMAL_SCALE];
   assign rsp_valid = chan_valid[vap_pkg::MAX_NORMAL_SCALE];

   always_comb begin
      rsp_data.word_x    = {last_vtx.nneg[0], last_best.t_x, last_vtx.pos_x};
      rsp_data.word_y    = {last_vtx.nneg[1], last_best.t_y, last_vtx.pos_y};
      rsp_data.word_z    = {last_vtx.nneg[2], last_best.t_z, last_vtx.pos_z};
      rsp_data.word_attr = last_vtx.attr;
   end

`ifndef ASSERT_OFF
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 chan_valid[0])
      else $error("front end dropped a request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      chan_valid[0] |-> $past(start, 2))
      else $error("front end produced a response without a request");
`endif

endmodule
